// ----- rtl/cor_pkg.sv -----
`default_nettype none

package cor_pkg;

  localparam int unsigned FIELD_BITS      = 16;
  localparam int unsigned IN_RADIUS_BITS  = 12;
  localparam int unsigned PIXELS_PER_STEP = 8;

  // midpoint decision constants
  localparam int unsigned DEC_INIT      = 3;
  localparam int unsigned DEC_INC_KEEP  = 6;
  localparam int unsigned DEC_INC_STEP  = 10;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                         operation;
    logic [FIELD_BITS-1:0]       center_x;
    logic [FIELD_BITS-1:0]       center_y;
    logic [IN_RADIUS_BITS-1:0]   radius;
    logic [FIELD_BITS-1:0]       draw_color;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] pixel_x;
    logic [FIELD_BITS-1:0] pixel_y;
    logic [FIELD_BITS-1:0] dot_color;
    logic                  pixel_valid;
    logic                  last_of_run;
    logic                  circle_done;
  } out_item_t;

  // One octant point handed from front to back. Offsets are already reduced
  // modulo the coordinate width; valid = 0 marks a step taken while idle.
  typedef struct packed {
    logic [FIELD_BITS-1:0] cx;
    logic [FIELD_BITS-1:0] cy;
    logic [FIELD_BITS-1:0] minor;
    logic [FIELD_BITS-1:0] major;
    logic [FIELD_BITS-1:0] color;
    logic                  valid;
    logic                  done;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/cor_ifs.sv -----
`default_nettype none

interface cor_in_if;
  logic              valid;
  logic              ready;
  cor_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cor_out_if;
  logic               valid;
  logic               ready;
  cor_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/circle_outline_rasterizer_core.sv -----
// The first pixel of a step passes through the job queue and then the output register.
// Each step yields eight pixels, one pixel per cycle through the output register while
//   out_o.ready allows; a start yields no output, a step while idle one result.
// The job queue (QUEUE_DEPTH entries) lets new items be taken while pixels drain.
// Reset: asynchronous, active low; block comes up idle with empty queue.
`default_nettype none

module circle_outline_rasterizer_core #(
  parameter int unsigned RADIUS_BITS = 12,
  parameter int unsigned COORD_BITS  = 16,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cor_in_if.sink    in_i,
  cor_out_if.source out_o
);

  // front -> queue
  logic               push;
  cor_pkg::job_t      job_wr;
  // queue -> back
  cor_pkg::job_t      job_rd;
  logic               pop;
  cor_pkg::q_status_t q_status;

  // Front: holds the midpoint state, turns each step into one octant job.
  cor_front #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (job_wr)
  );

  // Short job queue decoupling the input side from pixel drain.
  cor_job_fifo #(
    .WIDTH ($bits(cor_pkg::job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (job_wr),
    .pop_i    (pop),
    .rdata_o  (job_rd),
    .status_o (q_status)
  );

  // Back: walks the eight mirror images of the queue head, one per cycle while out_o is ready.
  cor_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job_rd),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

  // A step transaction always leaves a job queued for the back end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.data.operation == cor_pkg::OP_STEP)
      |=> !q_status.empty)
    else $error("step transaction did not queue a job");

  // An idle-step result is a single, all-zero, done-marked result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.pixel_valid)
      |-> (out_o.data.last_of_run && out_o.data.circle_done &&
           out_o.data.pixel_x == '0 && out_o.data.pixel_y == '0 &&
           out_o.data.dot_color == '0))
    else $error("malformed idle-step result");

  // The queue is never popped while empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("job queue popped while empty");

endmodule

`default_nettype wire

// ----- rtl/cor_job_fifo.sv -----
`default_nettype none

module cor_job_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output cor_pkg::q_status_t    status_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign status_o.full  = (count_q == CNT_FULL);
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cor_front.sv -----
`default_nettype none

module cor_front #(
  parameter int unsigned RADIUS_BITS = 12,
  parameter int unsigned COORD_BITS  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  cor_in_if.sink                  in_i,
  input  wire cor_pkg::q_status_t q_status_i,
  output logic                    push_o,
  output cor_pkg::job_t           job_o
);

  localparam int unsigned DEC_BITS = RADIUS_BITS + 4;
  localparam int unsigned WIDE     = RADIUS_BITS + cor_pkg::FIELD_BITS;
  localparam int unsigned RWIDE    = RADIUS_BITS + cor_pkg::IN_RADIUS_BITS;

  logic [COORD_BITS-1:0]           cx_q, cy_q;
  logic [cor_pkg::FIELD_BITS-1:0]  color_q;
  logic [RADIUS_BITS-1:0]          minor_q, minor_d;
  logic signed [RADIUS_BITS:0]     major_q, major_d;
  logic [DEC_BITS-1:0]             dec_q, dec_d;
  logic                            active_q, active_d;

  logic                   accept, is_step;
  logic [RWIDE-1:0]       radius_w;
  logic [RADIUS_BITS-1:0] radius;
  logic [WIDE-1:0]        minor_w, major_w;
  logic [RADIUS_BITS:0]   minor_inc;
  logic [DEC_BITS-1:0]    minor_dec, major_dec;
  logic                   step_done;

  assign in_i.ready = !q_status_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign is_step    = (in_i.data.operation == cor_pkg::OP_STEP);
  assign push_o     = accept && is_step;

  assign radius_w = RWIDE'(in_i.data.radius);
  assign radius   = radius_w[RADIUS_BITS-1:0];

  // offsets are non-negative while active, so the low bits of major suffice
  assign minor_w   = WIDE'(minor_q);
  assign major_w   = WIDE'(major_q[RADIUS_BITS-1:0]);
  assign minor_dec = DEC_BITS'(minor_q);
  assign major_dec = DEC_BITS'(major_q[RADIUS_BITS-1:0]);
  assign minor_inc = {1'b0, minor_q} + 1'b1;

  always_comb begin
    minor_d  = minor_q;
    major_d  = major_q;
    dec_d    = dec_q;
    active_d = active_q;
    if (dec_q[DEC_BITS-1]) begin
      dec_d = dec_q + (minor_dec << 2) + DEC_BITS'(cor_pkg::DEC_INC_KEEP);
    end else begin
      dec_d   = dec_q + ((minor_dec - major_dec) << 2) + DEC_BITS'(cor_pkg::DEC_INC_STEP);
      major_d = major_q - 1'b1;
    end
    minor_d   = minor_inc[RADIUS_BITS-1:0];
    step_done = $signed({major_d[RADIUS_BITS], major_d}) < $signed({1'b0, minor_inc});
    active_d  = !step_done;
  end

  always_comb begin
    job_o.cx    = cor_pkg::FIELD_BITS'(cx_q);
    job_o.cy    = cor_pkg::FIELD_BITS'(cy_q);
    job_o.minor = cor_pkg::FIELD_BITS'(minor_w[COORD_BITS-1:0]);
    job_o.major = cor_pkg::FIELD_BITS'(major_w[COORD_BITS-1:0]);
    job_o.color = color_q;
    job_o.valid = active_q;
    job_o.done  = active_q ? step_done : 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      color_q  <= '0;
      minor_q  <= '0;
      major_q  <= '0;
      dec_q    <= '0;
      active_q <= 1'b0;
    end else if (accept) begin
      if (!is_step) begin
        cx_q     <= in_i.data.center_x[COORD_BITS-1:0];
        cy_q     <= in_i.data.center_y[COORD_BITS-1:0];
        color_q  <= in_i.data.draw_color;
        minor_q  <= '0;
        major_q  <= $signed({1'b0, radius});
        dec_q    <= DEC_BITS'(cor_pkg::DEC_INIT) - (DEC_BITS'(radius) << 1);
        active_q <= 1'b1;
      end else if (active_q) begin
        minor_q  <= minor_d;
        major_q  <= major_d;
        dec_q    <= dec_d;
        active_q <= active_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cor_back.sv -----
`default_nettype none

module cor_back #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cor_pkg::job_t      job_i,
  input  wire cor_pkg::q_status_t q_status_i,
  output logic                    pop_o,
  cor_out_if.source               out_o
);

  localparam int unsigned IDX_BITS = $clog2(cor_pkg::PIXELS_PER_STEP);
  localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(cor_pkg::PIXELS_PER_STEP - 1);

  logic [IDX_BITS-1:0]   idx_q, idx_d;
  logic                  out_valid_q, out_valid_d;
  cor_pkg::out_item_t    out_q, out_d;
  logic                  advance, is_last;
  logic [COORD_BITS-1:0] x_off, y_off, x_base, y_base, x_pix, y_pix;

  assign advance = !out_valid_q || out_o.ready;
  assign is_last = !job_i.valid || (idx_q == IDX_LAST);
  assign pop_o   = advance && !q_status_i.empty && is_last;

  // idx[2] swaps the roles of minor/major, idx[0]/idx[1] flip x/y sign
  always_comb begin
    x_base = job_i.cx[COORD_BITS-1:0];
    y_base = job_i.cy[COORD_BITS-1:0];
    x_off  = idx_q[2] ? job_i.major[COORD_BITS-1:0] : job_i.minor[COORD_BITS-1:0];
    y_off  = idx_q[2] ? job_i.minor[COORD_BITS-1:0] : job_i.major[COORD_BITS-1:0];
    x_pix  = idx_q[0] ? x_base - x_off : x_base + x_off;
    y_pix  = idx_q[1] ? y_base - y_off : y_base + y_off;
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    if (advance) begin
      out_valid_d = !q_status_i.empty;
      if (job_i.valid) begin
        out_d.pixel_x   = cor_pkg::FIELD_BITS'(x_pix);
        out_d.pixel_y   = cor_pkg::FIELD_BITS'(y_pix);
        out_d.dot_color = job_i.color;
      end else begin
        out_d.pixel_x   = '0;
        out_d.pixel_y   = '0;
        out_d.dot_color = '0;
      end
      out_d.pixel_valid = job_i.valid;
      out_d.last_of_run = is_last;
      out_d.circle_done = job_i.done;
      if (!q_status_i.empty) begin
        idx_d = is_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire
